/* rtl/ep2rgb_pkg.sv */
`timescale 1ns / 1ps

package ep2rgb_pkg;

	// block configuration
	localparam int STEPS_PER_TURN = 24;
	localparam int CHANNEL_COUNT  = 4;

	// hue in 1/16 degree
	localparam int HUE_FULL    = 5760;
	localparam int HUE_SECTOR  = 960;
	localparam int HUE_CHANNEL = 1440;
	localparam int HUE_W       = 13;
	localparam int XW_W        = 10;

	// color arithmetic
	localparam int COLOR_W   = 8;
	localparam int COLOR_MAX = 255;
	localparam int CM_W      = 16;

	// count folded to a narrow word: hi * (2^16 mod N) + lo
	localparam longint unsigned FOLD_MAX   = 64'd65535 * STEPS_PER_TURN;
	localparam int              FOLD_W     = $clog2(FOLD_MAX + 1);
	localparam longint unsigned FOLD_RECIP = (64'd1 << FOLD_W) / STEPS_PER_TURN;
	localparam int              QUO_W      = 16;
	localparam int              REM_W      = $clog2(STEPS_PER_TURN + 1);
	localparam longint unsigned HALF_MOD   = 64'd65536 % STEPS_PER_TURN;
	localparam longint unsigned WORD_MOD   = (64'd1 << 32) % STEPS_PER_TURN;

	// remainder scaled onto the hue circle
	localparam int              SCALED_W     = $clog2(STEPS_PER_TURN * HUE_FULL);
	localparam longint unsigned SCALED_RECIP = (64'd1 << SCALED_W) / STEPS_PER_TURN;

	// component divisions
	localparam int              PART_DIV   = HUE_SECTOR * COLOR_MAX;
	localparam int              PART_W     = $clog2(2 * PART_DIV * COLOR_MAX + 1);
	localparam longint unsigned PART_RECIP = (64'd1 << PART_W) / PART_DIV;
	localparam longint unsigned ZERO_RECIP = (64'd1 << CM_W) / COLOR_MAX;

	typedef struct packed {
		logic [1:0]         channel;
		logic signed [31:0] step_count;
		logic               channel_ready;
	} req_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} rgb_t;

endpackage

/* rtl/ep2rgb_hue.sv */
`timescale 1ns / 1ps

module ep2rgb_hue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  ep2rgb_pkg::req_t            req,
	output logic                        hue_valid,
	input  logic                        hue_stall,
	output logic [ep2rgb_pkg::HUE_W-1:0] hue
);
	import ep2rgb_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6;

	logic [FOLD_W-1:0]   fold;
	logic [FOLD_W-1:0]   fold_s1, fold_s2;
	logic                neg_s1, neg_s2, neg_s3;
	logic [1:0]          chan_s1, chan_s2, chan_s3, chan_s4, chan_s5;
	logic [2*FOLD_W:0]   fold_prod;
	logic [QUO_W-1:0]    quo_s2;
	logic [FOLD_W-1:0]   fold_diff, fold_rem;
	logic [REM_W-1:0]    rem_s3;
	logic [REM_W:0]      rem_ext, rem_adj;
	logic [SCALED_W-1:0] scaled_s4, scaled_s5;
	logic [2*SCALED_W:0] scaled_prod;
	logic [HUE_W-1:0]    hq_s5;
	logic [SCALED_W-1:0] scaled_diff;
	logic [HUE_W:0]      hue_base, hue_sum;
	logic [HUE_W-1:0]    hue_s6;

	// stage advance: a stage moves when empty or when the next one moves
	assign adv_s6    = !valid_s6 || !hue_stall;
	assign adv_s5    = !valid_s5 || adv_s6;
	assign adv_s4    = !valid_s4 || adv_s5;
	assign adv_s3    = !valid_s3 || adv_s4;
	assign adv_s2    = !valid_s2 || adv_s3;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req_stall = !adv_s1;

	// fold the 32-bit word: 2^16 is replaced by its residue
	assign fold = FOLD_W'(req.step_count[31:16]) * FOLD_W'(HALF_MOD)
		+ FOLD_W'(req.step_count[15:0]);

	// quotient estimate by reciprocal, low by at most one
	assign fold_prod = (2*FOLD_W+1)'(fold_s1) * (2*FOLD_W+1)'(FOLD_RECIP);

	// remainder with one correction step
	always_comb begin
		fold_diff = fold_s2 - FOLD_W'(FOLD_W'(quo_s2) * FOLD_W'(STEPS_PER_TURN));
		if (fold_diff >= FOLD_W'(STEPS_PER_TURN)) begin
			fold_rem = fold_diff - FOLD_W'(STEPS_PER_TURN);
		end else begin
			fold_rem = fold_diff;
		end
	end

	// negative word: take off the residue of 2^32, keep non-negative
	always_comb begin
		rem_ext = (REM_W+1)'(rem_s3);
		if (!neg_s3) begin
			rem_adj = rem_ext;
		end else if (rem_ext >= (REM_W+1)'(WORD_MOD)) begin
			rem_adj = rem_ext - (REM_W+1)'(WORD_MOD);
		end else begin
			rem_adj = rem_ext + (REM_W+1)'(STEPS_PER_TURN) - (REM_W+1)'(WORD_MOD);
		end
	end

	// hue estimate by reciprocal
	assign scaled_prod = (2*SCALED_W+1)'(scaled_s4) * (2*SCALED_W+1)'(SCALED_RECIP);

	// hue correction, channel offset and wrap
	always_comb begin
		scaled_diff = scaled_s5 - SCALED_W'(SCALED_W'(hq_s5) * SCALED_W'(STEPS_PER_TURN));
		hue_base    = (HUE_W+1)'(hq_s5);
		if (scaled_diff >= SCALED_W'(STEPS_PER_TURN)) begin
			hue_base = hue_base + (HUE_W+1)'(1);
		end
		hue_sum = hue_base + (HUE_W+1)'(chan_s5) * (HUE_W+1)'(HUE_CHANNEL);
		if (hue_sum >= (HUE_W+1)'(HUE_FULL)) begin
			hue_sum = hue_sum - (HUE_W+1)'(HUE_FULL);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= req_valid && req.channel_ready
					&& (int'(req.channel) < CHANNEL_COUNT);
			end
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
			if (adv_s5) valid_s5 <= valid_s4;
			if (adv_s6) valid_s6 <= valid_s5;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			fold_s1 <= fold;
			neg_s1  <= req.step_count[31];
			chan_s1 <= req.channel;
		end
		if (adv_s2) begin
			fold_s2 <= fold_s1;
			quo_s2  <= fold_prod[FOLD_W +: QUO_W];
			neg_s2  <= neg_s1;
			chan_s2 <= chan_s1;
		end
		if (adv_s3) begin
			rem_s3  <= REM_W'(fold_rem);
			neg_s3  <= neg_s2;
			chan_s3 <= chan_s2;
		end
		if (adv_s4) begin
			scaled_s4 <= SCALED_W'(rem_adj) * SCALED_W'(HUE_FULL);
			chan_s4   <= chan_s3;
		end
		if (adv_s5) begin
			scaled_s5 <= scaled_s4;
			hq_s5     <= scaled_prod[SCALED_W +: HUE_W];
			chan_s5   <= chan_s4;
		end
		if (adv_s6) begin
			hue_s6 <= HUE_W'(hue_sum);
		end
	end

	assign hue_valid = valid_s6;
	assign hue       = hue_s6;

	// remainder is always reduced
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (int'(rem_s3) < STEPS_PER_TURN))
		else $error("remainder not reduced");

	// hue stays on the circle
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hue_valid |-> (int'(hue) < HUE_FULL))
		else $error("hue out of range");

endmodule

/* rtl/ep2rgb_color.sv */
`timescale 1ns / 1ps

module ep2rgb_color (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           hue_valid,
	output logic                           hue_stall,
	input  logic [ep2rgb_pkg::HUE_W-1:0]   hue,
	input  logic [ep2rgb_pkg::COLOR_W-1:0] saturation,
	input  logic [ep2rgb_pkg::COLOR_W-1:0] brightness,
	output logic                           rgb_valid,
	input  logic                           rgb_stall,
	output ep2rgb_pkg::rgb_t               rgb
);
	import ep2rgb_pkg::*;

	typedef enum logic [2:0] {
		SECT_RY, SECT_YG, SECT_GC, SECT_CB, SECT_BM, SECT_MR
	} sector_t;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	sector_t             sector;
	sector_t             sector_s1, sector_s2, sector_s3;
	logic [HUE_W-1:0]    t_hue;
	logic [XW_W-1:0]     xw;
	logic [XW_W-1:0]     xw_s1;
	logic [CM_W-1:0]     chroma_s1, level_s1, level_s2, level_s3;
	logic [PART_W-1:0]   part_num_s2, part_num_s3;
	logic [PART_W+XW_W-1:0] part_prod;
	logic [2*CM_W-1:0]   zero_prod;
	logic [COLOR_W-1:0]  part_q_s3, zero_q_s3;
	logic [PART_W-1:0]   part_diff;
	logic [CM_W-1:0]     zero_diff;
	logic [COLOR_W-1:0]  part_val, zero_val, full_val;
	rgb_t                rgb_next;
	rgb_t                rgb_s4;

	// stage advance
	assign adv_s4    = !valid_s4 || !rgb_stall;
	assign adv_s3    = !valid_s3 || adv_s4;
	assign adv_s2    = !valid_s2 || adv_s3;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign hue_stall = !adv_s1;

	// sector and ramp position
	always_comb begin
		if (int'(hue) < HUE_SECTOR) begin
			sector = SECT_RY;
		end else if (int'(hue) < 2 * HUE_SECTOR) begin
			sector = SECT_YG;
		end else if (int'(hue) < 3 * HUE_SECTOR) begin
			sector = SECT_GC;
		end else if (int'(hue) < 4 * HUE_SECTOR) begin
			sector = SECT_CB;
		end else if (int'(hue) < 5 * HUE_SECTOR) begin
			sector = SECT_BM;
		end else begin
			sector = SECT_MR;
		end
		if (int'(hue) < 2 * HUE_SECTOR) begin
			t_hue = hue;
		end else if (int'(hue) < 4 * HUE_SECTOR) begin
			t_hue = hue - HUE_W'(2 * HUE_SECTOR);
		end else begin
			t_hue = hue - HUE_W'(4 * HUE_SECTOR);
		end
		if (int'(t_hue) < HUE_SECTOR) begin
			xw = XW_W'(t_hue);
		end else begin
			xw = XW_W'(HUE_W'(2 * HUE_SECTOR) - t_hue);
		end
	end

	// quotient estimates by reciprocal
	assign part_prod = (PART_W+XW_W)'(part_num_s2) * (PART_W+XW_W)'(PART_RECIP);
	assign zero_prod = (2*CM_W)'(level_s2) * (2*CM_W)'(ZERO_RECIP);

	// corrections and component routing
	always_comb begin
		part_diff = part_num_s3 - PART_W'(PART_W'(part_q_s3) * PART_W'(PART_DIV));
		zero_diff = level_s3 - CM_W'(CM_W'(zero_q_s3) * CM_W'(COLOR_MAX));
		part_val  = part_q_s3;
		zero_val  = zero_q_s3;
		if (part_diff >= PART_W'(PART_DIV)) part_val = part_q_s3 + COLOR_W'(1);
		if (zero_diff >= CM_W'(COLOR_MAX))  zero_val = zero_q_s3 + COLOR_W'(1);
		// chroma plus offset is brightness times full scale
		full_val = brightness;
		case (sector_s3)
			SECT_RY: rgb_next = '{red: full_val, green: part_val, blue: zero_val};
			SECT_YG: rgb_next = '{red: part_val, green: full_val, blue: zero_val};
			SECT_GC: rgb_next = '{red: zero_val, green: full_val, blue: part_val};
			SECT_CB: rgb_next = '{red: zero_val, green: part_val, blue: full_val};
			SECT_BM: rgb_next = '{red: part_val, green: zero_val, blue: full_val};
			default: rgb_next = '{red: full_val, green: zero_val, blue: part_val};
		endcase
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= hue_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			sector_s1 <= sector;
			xw_s1     <= xw;
			chroma_s1 <= CM_W'(saturation) * CM_W'(brightness);
			level_s1  <= CM_W'(brightness) * CM_W'(COLOR_MAX)
				- CM_W'(saturation) * CM_W'(brightness);
		end
		if (adv_s2) begin
			sector_s2   <= sector_s1;
			level_s2    <= level_s1;
			part_num_s2 <= PART_W'(chroma_s1) * PART_W'(xw_s1)
				+ PART_W'(level_s1) * PART_W'(HUE_SECTOR);
		end
		if (adv_s3) begin
			sector_s3   <= sector_s2;
			level_s3    <= level_s2;
			part_num_s3 <= part_num_s2;
			part_q_s3   <= part_prod[PART_W +: COLOR_W];
			zero_q_s3   <= zero_prod[CM_W +: COLOR_W];
		end
		if (adv_s4) begin
			rgb_s4 <= rgb_next;
		end
	end

	assign rgb_valid = valid_s4;
	assign rgb       = rgb_s4;

	// ramp position never passes one sector
	a_ramp_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (int'(xw_s1) <= HUE_SECTOR))
		else $error("ramp position out of range");

	// reciprocal estimate is off by at most one
	a_part_est: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (part_diff < PART_W'(2 * PART_DIV)))
		else $error("part estimate off by more than one");

	a_zero_est: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (zero_diff < CM_W'(2 * COLOR_MAX)))
		else $error("offset estimate off by more than one");

endmodule

/* rtl/encoder_position_to_rgb.sv */
`timescale 1ns / 1ps

// channel  | direction | handshake                  | payload
// req      | in        | req_valid / req_stall      | channel, step_count, channel_ready
// rgb      | out       | rgb_valid / rgb_stall      | red, green, blue
// config   | in        | psel / penable / pwrite    | paddr, pwdata, prdata (pready high)
//
// one request accepted per cycle while req_stall is low; the result reaches rgb
// after six stages of hue arithmetic and four of color arithmetic
// requests not ready, or for a channel beyond the count, leave no result
// reset clears all stage valid bits and sets saturation and brightness to 255
// a stall holds only the stages that are full; bubbles still move up, and
// req_stall follows rgb_stall through the stage chain in the same cycle

module encoder_position_to_rgb (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              req_valid,
	output logic              req_stall,
	input  ep2rgb_pkg::req_t  req,
	output logic              rgb_valid,
	input  logic              rgb_stall,
	output ep2rgb_pkg::rgb_t  rgb
);
	import ep2rgb_pkg::*;

	localparam logic REG_SATURATION = 1'b0;
	localparam logic REG_BRIGHTNESS = 1'b1;

	logic [COLOR_W-1:0] saturation_q;
	logic [COLOR_W-1:0] brightness_q;
	logic               hue_valid;
	logic               hue_stall;
	logic [HUE_W-1:0]   hue;

	// configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saturation_q <= COLOR_W'(COLOR_MAX);
			brightness_q <= COLOR_W'(COLOR_MAX);
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_SATURATION: saturation_q <= pwdata[COLOR_W-1:0];
				REG_BRIGHTNESS: brightness_q <= pwdata[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[2])
			REG_SATURATION: prdata = 32'(saturation_q);
			REG_BRIGHTNESS: prdata = 32'(brightness_q);
			default:        prdata = '0;
		endcase
	end

	// hue pipeline
	ep2rgb_hue u_hue (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.hue_valid (hue_valid),
		.hue_stall (hue_stall),
		.hue       (hue)
	);

	// color pipeline
	ep2rgb_color u_color (
		.clk        (clk),
		.arst_n     (arst_n),
		.hue_valid  (hue_valid),
		.hue_stall  (hue_stall),
		.hue        (hue),
		.saturation (saturation_q),
		.brightness (brightness_q),
		.rgb_valid  (rgb_valid),
		.rgb_stall  (rgb_stall),
		.rgb        (rgb)
	);

endmodule
